[src/bond_transition_histogram_unit_macros.svh]
// ----------------------------------------------------------------------------
// bond transition histogram assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef BOND_TRANSITION_HISTOGRAM_UNIT_MACROS_SVH
`define BOND_TRANSITION_HISTOGRAM_UNIT_MACROS_SVH

// same-cycle implication
`define BTH_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTH_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/btransh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btransh_pkg
// shared widths, request codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package btransh_pkg;

  localparam int DEF_MAX_TYPES   = 8;
  localparam int DEF_COUNT_WIDTH = 32;
  localparam int DEF_INDEX_WIDTH = 16;

  localparam int REQ_W  = 2;
  localparam int PART_W = 16;
  localparam int TYPE_W = 3;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 3;
  localparam int NT_W   = 4;
  localparam int BIN_W  = 32;

  localparam logic [NT_W-1:0] NUM_TYPES_RST = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef struct packed {
    logic load;
    logic rd_first;
    logic wr_first;
    logic rd_second;
    logic wr_second;
    logic clr_step;
    logic out_load;
  } btransh_cmd_t;

  typedef struct packed {
    req_t req;
    logic rec_lost;
    logic rec_formed;
    logic read_ok;
    logic clr_last;
    logic out_free;
  } btransh_sts_t;

endpackage

[src/bond_transition_histogram_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bond_transition_histogram_unit
// bond formed/lost/switched histogram with saturating bins, read and clear
// ----------------------------------------------------------------------------
// One item is taken at a time. A record item with no transition, or with a
// type error, goes from capture through decode to the result state; a formed or
// lost bond adds one bin update and a partner switch two, since each bin update
// is a read-modify-write through the single write port of the bin memory. A read
// goes through decode, where the bin is read, to the result state. A clear request
// sweeps the memory one entry a cycle; after reset the same sweep runs before the
// first input transfer is taken, while num_types writes are taken as usual. A
// finished result sits in an output register, so the next input transfer can
// start while it waits.
// ----------------------------------------------------------------------------
module bond_transition_histogram_unit #(
  parameter int MAX_TYPES   = btransh_pkg::DEF_MAX_TYPES,
  parameter int COUNT_WIDTH = btransh_pkg::DEF_COUNT_WIDTH,
  parameter int INDEX_WIDTH = btransh_pkg::DEF_INDEX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [btransh_pkg::NT_W-1:0]   cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [btransh_pkg::REQ_W-1:0]  in_req_type,
  input  logic                           in_bound_before,
  input  logic                           in_bound_after,
  input  logic [btransh_pkg::PART_W-1:0] in_partner_before,
  input  logic [btransh_pkg::PART_W-1:0] in_partner_after,
  input  logic [btransh_pkg::TYPE_W-1:0] in_type_self,
  input  logic [btransh_pkg::TYPE_W-1:0] in_type_partner_before,
  input  logic [btransh_pkg::TYPE_W-1:0] in_type_partner_after,
  input  logic [btransh_pkg::ROW_W-1:0]  in_read_row,
  input  logic [btransh_pkg::COL_W-1:0]  in_read_col,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [btransh_pkg::BIN_W-1:0]  out_bin_count,
  output logic                           out_formed,
  output logic                           out_lost,
  output logic                           out_type_error
);
  import btransh_pkg::*;

  btransh_cmd_t cmd;
  btransh_sts_t sts;

  btransh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  btransh_dp #(
    .MAX_TYPES   (MAX_TYPES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_req_type            (in_req_type),
    .in_bound_before        (in_bound_before),
    .in_bound_after         (in_bound_after),
    .in_partner_before      (in_partner_before),
    .in_partner_after       (in_partner_after),
    .in_type_self           (in_type_self),
    .in_type_partner_before (in_type_partner_before),
    .in_type_partner_after  (in_type_partner_after),
    .in_read_row            (in_read_row),
    .in_read_col            (in_read_col),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_bin_count          (out_bin_count),
    .out_formed             (out_formed),
    .out_lost               (out_lost),
    .out_type_error         (out_type_error)
  );

endmodule

[src/btransh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btransh_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module btransh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

[src/btransh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btransh_dp
// item capture, transition classification, bin addressing, saturating
// read-modify-write on the bin memory, clear sweep and result register
// ----------------------------------------------------------------------------
`include "bond_transition_histogram_unit_macros.svh"

module btransh_dp #(
  parameter int MAX_TYPES   = btransh_pkg::DEF_MAX_TYPES,
  parameter int COUNT_WIDTH = btransh_pkg::DEF_COUNT_WIDTH,
  parameter int INDEX_WIDTH = btransh_pkg::DEF_INDEX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [btransh_pkg::NT_W-1:0]      cfg_wr_data,
  input  logic [btransh_pkg::REQ_W-1:0]     in_req_type,
  input  logic                              in_bound_before,
  input  logic                              in_bound_after,
  input  logic [btransh_pkg::PART_W-1:0]    in_partner_before,
  input  logic [btransh_pkg::PART_W-1:0]    in_partner_after,
  input  logic [btransh_pkg::TYPE_W-1:0]    in_type_self,
  input  logic [btransh_pkg::TYPE_W-1:0]    in_type_partner_before,
  input  logic [btransh_pkg::TYPE_W-1:0]    in_type_partner_after,
  input  logic [btransh_pkg::ROW_W-1:0]     in_read_row,
  input  logic [btransh_pkg::COL_W-1:0]     in_read_col,
  input  btransh_pkg::btransh_cmd_t         cmd,
  output btransh_pkg::btransh_sts_t         sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [btransh_pkg::BIN_W-1:0]     out_bin_count,
  output logic                              out_formed,
  output logic                              out_lost,
  output logic                              out_type_error
);
  import btransh_pkg::*;

  localparam int DEPTH = 2 * MAX_TYPES * MAX_TYPES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = ($clog2(2 * MAX_TYPES + 1) > NT_W) ? $clog2(2 * MAX_TYPES + 1) : NT_W;
  localparam int PW    = (INDEX_WIDTH < PART_W) ? INDEX_WIDTH : PART_W;

  // config register
  logic [NT_W-1:0] num_types_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_types_r <= NUM_TYPES_RST;
    end else if (cfg_wr_en) begin
      num_types_r <= cfg_wr_data;
    end
  end

  // captured item
  logic [REQ_W-1:0]  req_r;
  logic              bb_r;
  logic              ba_r;
  logic [PW-1:0]     pb_r;
  logic [PW-1:0]     pa_r;
  logic [TYPE_W-1:0] ts_r;
  logic [TYPE_W-1:0] tpb_r;
  logic [TYPE_W-1:0] tpa_r;
  logic [ROW_W-1:0]  rr_r;
  logic [COL_W-1:0]  rc_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      bb_r  <= in_bound_before;
      ba_r  <= in_bound_after;
      pb_r  <= in_partner_before[PW-1:0];
      pa_r  <= in_partner_after[PW-1:0];
      ts_r  <= in_type_self;
      tpb_r <= in_type_partner_before;
      tpa_r <= in_type_partner_after;
      rr_r  <= in_read_row;
      rc_r  <= in_read_col;
    end
  end

  // classification
  logic [NW-1:0] nt;
  logic [NW-1:0] nt2;
  logic          is_switch;
  logic          f_raw;
  logic          l_raw;
  logic          rec_bad;
  logic          read_err;
  logic          formed_ok;
  logic          lost_ok;

  always_comb begin
    nt        = (NW'(num_types_r) > NW'(MAX_TYPES)) ? NW'(MAX_TYPES) : NW'(num_types_r);
    nt2       = NW'(nt << 1);
    is_switch = bb_r && ba_r && (pb_r != pa_r);
    f_raw     = (!bb_r && ba_r) || is_switch;
    l_raw     = (bb_r && !ba_r) || is_switch;
    rec_bad   = (f_raw || l_raw) &&
                ((NW'(ts_r) >= nt) || (f_raw && (NW'(tpa_r) >= nt)) ||
                 (l_raw && (NW'(tpb_r) >= nt)));
    read_err  = (NW'(rr_r) >= nt2) || (NW'(rc_r) >= nt);
    formed_ok = f_raw && !rec_bad;
    lost_ok   = l_raw && !rec_bad;
  end

  // bin addresses, row * MAX_TYPES + col
  logic [AW-1:0] formed_addr;
  logic [AW-1:0] lost_addr;
  logic [AW-1:0] read_addr;
  logic [AW-1:0] first_addr;

  always_comb begin
    formed_addr = AW'(AW'(ts_r) * AW'(MAX_TYPES) + AW'(tpa_r));
    lost_addr   = AW'(AW'(NW'(nt + NW'(ts_r))) * AW'(MAX_TYPES) + AW'(tpb_r));
    read_addr   = AW'(AW'(rr_r) * AW'(MAX_TYPES) + AW'(rc_r));
    if (req_t'(req_r) == REQ_READ) begin
      first_addr = read_addr;
    end else if (lost_ok) begin
      first_addr = lost_addr;
    end else begin
      first_addr = formed_addr;
    end
  end

  // clear sweep counter
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] clr_cnt_nxt;
  logic          clr_last;

  assign clr_last    = (clr_cnt_r == AW'(DEPTH - 1));
  assign clr_cnt_nxt = clr_last ? '0 : AW'(clr_cnt_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // bin memory
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] bin_inc;

  assign bin_inc = (ram_rdata == '1) ? ram_rdata : COUNT_WIDTH'(ram_rdata + 1'b1);

  always_comb begin
    ram_we    = cmd.wr_first || cmd.wr_second || cmd.clr_step;
    ram_re    = cmd.rd_first || cmd.rd_second;
    ram_raddr = cmd.rd_second ? formed_addr : first_addr;
    if (cmd.clr_step) begin
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.wr_second) begin
      ram_waddr = formed_addr;
      ram_wdata = bin_inc;
    end else begin
      ram_waddr = first_addr;
      ram_wdata = bin_inc;
    end
  end

  btransh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // 32-bit view of a bin, saturating wide counters
  logic [BIN_W-1:0] count32;

  generate
    if (COUNT_WIDTH > BIN_W) begin : g_wide
      assign count32 = (|ram_rdata[COUNT_WIDTH-1:BIN_W]) ? '1 : ram_rdata[BIN_W-1:0];
    end else begin : g_narrow
      assign count32 = BIN_W'(ram_rdata);
    end
  endgenerate

  // result register
  logic             out_valid_r;
  logic [BIN_W-1:0] out_count_r;
  logic             out_formed_r;
  logic             out_lost_r;
  logic             out_err_r;
  logic             is_rec;
  logic             is_read;

  assign is_rec  = (req_t'(req_r) == REQ_RECORD);
  assign is_read = (req_t'(req_r) == REQ_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r  <= (is_read && !read_err) ? count32 : '0;
      out_formed_r <= is_rec && formed_ok;
      out_lost_r   <= is_rec && lost_ok;
      out_err_r    <= (is_rec && rec_bad) || (is_read && read_err);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_count  = out_count_r;
  assign out_formed     = out_formed_r;
  assign out_lost       = out_lost_r;
  assign out_type_error = out_err_r;

  always_comb begin
    sts.req        = req_t'(req_r);
    sts.rec_lost   = lost_ok;
    sts.rec_formed = formed_ok;
    sts.read_ok    = !read_err;
    sts.clr_last   = clr_last;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // formed and lost bins of one item never collide in the memory
  `BTH_ASSERT_IMP(a_no_rw_collision, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr,
                  "bin write and read hit the same entry")
  `BTH_ASSERT_IMP(a_load_only_free, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall,
                  "result loaded over a pending transfer")

endmodule

[src/btransh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btransh_ctrl
// sequencer for item acceptance, bin read-modify-write, clear sweep and result
// ----------------------------------------------------------------------------
`include "bond_transition_histogram_unit_macros.svh"

module btransh_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  btransh_pkg::btransh_sts_t sts,
  output btransh_pkg::btransh_cmd_t cmd
);
  import btransh_pkg::*;

  typedef enum logic [2:0] {
    S_CLR_INIT,
    S_IDLE,
    S_EXEC,
    S_UPD_A,
    S_UPD_B,
    S_CLR_REQ,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.req)
          REQ_RECORD: begin
            if (sts.rec_lost || sts.rec_formed) begin
              cmd.rd_first = 1'b1;
              state_nxt    = S_UPD_A;
            end else begin
              state_nxt = S_RESP;
            end
          end
          REQ_READ: begin
            cmd.rd_first = sts.read_ok;
            state_nxt    = S_RESP;
          end
          REQ_CLEAR: begin
            state_nxt = S_CLR_REQ;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_UPD_A: begin
        cmd.wr_first = 1'b1;
        if (sts.rec_lost && sts.rec_formed) begin
          cmd.rd_second = 1'b1;
          state_nxt     = S_UPD_B;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_UPD_B: begin
        cmd.wr_second = 1'b1;
        state_nxt     = S_RESP;
      end
      S_CLR_REQ: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BTH_ASSERT_NXT(a_load_to_exec, clk, rst_n, cmd.load, state_r == S_EXEC,
                  "accepted item not decoded next cycle")
  `BTH_ASSERT_IMP(a_second_after_first, clk, rst_n, state_r == S_UPD_B,
                  $past(state_r) == S_UPD_A, "second bin update without first")
  `BTH_ASSERT_IMP(a_second_needs_both, clk, rst_n, cmd.rd_second,
                  sts.rec_lost && sts.rec_formed, "second bin read on a single transition")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the bond transition histogram unit against a cycle-free scoreboard
// model. A table of hand-picked transfers covers formed, lost, switched and
// unchanged bonds, reads, clears and out-of-range types. Randomized phases
// follow, one per type plan entry (counts 0 to 15). Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import btransh_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 10;
  localparam int MAX_GAP         = 16;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTS     = 10;
  localparam int BIN_DEPTH       = 2 * DEF_MAX_TYPES * DEF_MAX_TYPES;
  localparam int BIN_AW          = $clog2(BIN_DEPTH);
  localparam int NUM_PHASES      = 17;
  localparam int NUM_DIRECTED    = 25;

  typedef struct packed {
    req_t              req;
    logic              bound_before;
    logic              bound_after;
    logic [PART_W-1:0] partner_before;
    logic [PART_W-1:0] partner_after;
    logic [TYPE_W-1:0] type_self;
    logic [TYPE_W-1:0] type_partner_before;
    logic [TYPE_W-1:0] type_partner_after;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } transition_req_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_count;
    logic             formed;
    logic             lost;
    logic             type_error;
  } bin_result_t;

  typedef struct packed {
    logic            set_types;
    logic [NT_W-1:0] num_types;
    transition_req_t item;
    logic            typed;
    bin_result_t     result;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [NT_W-1:0]   cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [REQ_W-1:0]  in_req_type;
  logic              in_bound_before;
  logic              in_bound_after;
  logic [PART_W-1:0] in_partner_before;
  logic [PART_W-1:0] in_partner_after;
  logic [TYPE_W-1:0] in_type_self;
  logic [TYPE_W-1:0] in_type_partner_before;
  logic [TYPE_W-1:0] in_type_partner_after;
  logic [ROW_W-1:0]  in_read_row;
  logic [COL_W-1:0]  in_read_col;
  logic              out_valid;
  logic              out_stall;
  logic [BIN_W-1:0]  out_bin_count;
  logic              out_formed;
  logic              out_lost;
  logic              out_type_error;

  logic [BIN_W-1:0] model_bins [BIN_DEPTH];
  logic [NT_W-1:0]  model_num_types;
  bin_result_t      expected_results [$];
  int               error_count = 0;
  int               cycle_count = 0;
  logic             idle_enabled = 1'b1;

  logic [NT_W-1:0] type_plan [NUM_PHASES] = '{
    4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
    4'd6, 4'd9, 4'd12, 4'd10, 4'd11, 4'd13, 4'd14, 4'd8
  };

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // fresh bins, full type range
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd15, 3'd7},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b0, 1'b1, 16'h0000, 16'hFFFF, 3'd7, 3'd0, 3'd7, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 3'd0, 3'd0, 3'd7, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 3'd3, 3'd5, 3'd2, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7, 3'd7, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 3'd7, 3'd7, 3'd7, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd7, 3'd7},
      1'b0, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd11, 3'd5},
      1'b0, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd3, 3'd2},
      1'b0, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_NOP, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7, 3'd7, 4'd15, 3'd7},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_CLEAR, 1'b0, 1'b1, 16'h0000, 16'hFFFF, 3'd7, 3'd0, 3'd7, 4'd7, 3'd7},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd7, 3'd7},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    // three types in use
    '{1'b1, 4'd3, '{REQ_RECORD, 1'b0, 1'b1, 16'h0000, 16'h0001, 3'd3, 3'd0, 3'd0, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b0, 1'b1, 16'h0000, 16'h0001, 3'd0, 3'd0, 3'd3, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b1, 1'b0, 16'h0001, 16'h0000, 3'd2, 3'd7, 3'd0, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b1, 1'b1, 16'h0001, 16'h0002, 3'd1, 3'd1, 3'd4, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b1, 1'b0, 16'h0001, 16'h0000, 3'd2, 3'd2, 3'd7, 4'd0, 3'd0},
      1'b0, '{32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd6, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd5, 3'd3},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd5, 3'd2},
      1'b0, '{32'd0, 1'b0, 1'b0, 1'b0}},
    // no types in use
    '{1'b1, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 4'd0, '{REQ_RECORD, 1'b0, 1'b1, 16'h0000, 16'h0001, 3'd0, 3'd0, 3'd0, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
    // type count above the maximum
    '{1'b1, 4'd15, '{REQ_RECORD, 1'b0, 1'b1, 16'h0000, 16'h0001, 3'd7, 3'd0, 3'd7, 4'd0, 3'd0},
      1'b1, '{32'd0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 4'd0, '{REQ_READ, 1'b0, 1'b0, 16'h0000, 16'h0000, 3'd0, 3'd0, 3'd0, 4'd15, 3'd7},
      1'b0, '{32'd0, 1'b0, 1'b0, 1'b0}}
  };

  bond_transition_histogram_unit DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_bound_before        (in_bound_before),
    .in_bound_after         (in_bound_after),
    .in_partner_before      (in_partner_before),
    .in_partner_after       (in_partner_after),
    .in_type_self           (in_type_self),
    .in_type_partner_before (in_type_partner_before),
    .in_type_partner_after  (in_type_partner_after),
    .in_read_row            (in_read_row),
    .in_read_col            (in_read_col),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_bin_count          (out_bin_count),
    .out_formed             (out_formed),
    .out_lost               (out_lost),
    .out_type_error         (out_type_error)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic void bump_bin(int row, int col);
    int addr;
    addr = row * DEF_MAX_TYPES + col;
    if (model_bins[BIN_AW'(addr)] != '1) begin
      model_bins[BIN_AW'(addr)] = model_bins[BIN_AW'(addr)] + 1'b1;
    end
  endfunction

  function automatic bin_result_t predict_transition(transition_req_t t);
    bin_result_t r;
    int          nt;
    logic        formed;
    logic        lost;
    logic        bad;
    r      = '0;
    formed = 1'b0;
    lost   = 1'b0;
    nt     = (model_num_types > DEF_MAX_TYPES) ? DEF_MAX_TYPES : int'(model_num_types);
    case (t.req)
      REQ_RECORD: begin
        if (!t.bound_before && t.bound_after) begin
          formed = 1'b1;
        end else if (t.bound_before && !t.bound_after) begin
          lost = 1'b1;
        end else if (t.bound_before && t.bound_after &&
                     t.partner_before != t.partner_after) begin
          formed = 1'b1;
          lost   = 1'b1;
        end
        if (formed || lost) begin
          bad = (int'(t.type_self) >= nt) ||
                (formed && int'(t.type_partner_after) >= nt) ||
                (lost && int'(t.type_partner_before) >= nt);
          if (bad) begin
            r.type_error = 1'b1;
          end else begin
            if (lost) begin
              bump_bin(nt + int'(t.type_self), int'(t.type_partner_before));
            end
            if (formed) begin
              bump_bin(int'(t.type_self), int'(t.type_partner_after));
            end
            r.formed = formed;
            r.lost   = lost;
          end
        end
      end
      REQ_READ: begin
        if (int'(t.read_row) >= 2 * nt || int'(t.read_col) >= nt) begin
          r.type_error = 1'b1;
        end else begin
          r.bin_count = model_bins[BIN_AW'(int'(t.read_row) * DEF_MAX_TYPES +
                                           int'(t.read_col))];
        end
      end
      REQ_CLEAR: begin
        foreach (model_bins[i]) model_bins[i] = '0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic transition_req_t random_transition();
    transition_req_t t;
    int              nt;
    int              pick;
    nt                    = (model_num_types > DEF_MAX_TYPES) ? DEF_MAX_TYPES :
                            int'(model_num_types);
    pick                  = $urandom_range(0, 99);
    t.req                 = req_t'($urandom_range(0, 3));
    t.bound_before        = 1'($urandom_range(0, 1));
    t.bound_after         = 1'($urandom_range(0, 1));
    t.partner_before      = PART_W'($urandom_range(0, 65535));
    t.partner_after       = ($urandom_range(0, 2) == 0) ? t.partner_before :
                            PART_W'($urandom_range(0, 65535));
    t.type_self           = TYPE_W'($urandom_range(0, 7));
    t.type_partner_before = TYPE_W'($urandom_range(0, 7));
    t.type_partner_after  = TYPE_W'($urandom_range(0, 7));
    t.read_row            = ROW_W'($urandom_range(0, 15));
    t.read_col            = COL_W'($urandom_range(0, 7));
    if (pick < 60) begin
      t.req = REQ_RECORD;
      if (nt > 0 && $urandom_range(0, 9) != 0) begin
        t.type_self           = TYPE_W'($urandom_range(0, nt - 1));
        t.type_partner_before = TYPE_W'($urandom_range(0, nt - 1));
        t.type_partner_after  = TYPE_W'($urandom_range(0, nt - 1));
      end
    end else if (pick < 85) begin
      t.req = REQ_READ;
      if (nt > 0 && $urandom_range(0, 9) != 0) begin
        t.read_row = ROW_W'($urandom_range(0, 2 * nt - 1));
        t.read_col = COL_W'($urandom_range(0, nt - 1));
      end
    end else if (pick < 87) begin
      t.req = REQ_CLEAR;
    end
    return t;
  endfunction

  task automatic flag_error(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  task automatic send_transfer(transition_req_t t, logic typed, bin_result_t typed_result);
    int          gap;
    bin_result_t predicted;
    gap = idle_enabled ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type            <= t.req;
    in_bound_before        <= t.bound_before;
    in_bound_after         <= t.bound_after;
    in_partner_before      <= t.partner_before;
    in_partner_after       <= t.partner_after;
    in_type_self           <= t.type_self;
    in_type_partner_before <= t.type_partner_before;
    in_type_partner_after  <= t.type_partner_after;
    in_read_row            <= t.read_row;
    in_read_col            <= t.read_col;
    in_valid               <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = predict_transition(t);
    expected_results.insert(expected_results.size(), typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_num_types(logic [NT_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en       <= 1'b0;
    model_num_types = value;
  endtask

  // result side stall
  initial begin
    int stall_cycles;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall_cycles = idle_enabled ? $urandom_range(0, MAX_GAP) : 0;
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // result checking
  always @(posedge clk) begin
    bin_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected transfer: count=%0h formed=%0b lost=%0b err=%0b",
                             out_bin_count, out_formed, out_lost, out_type_error));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_bin_count !== exp_r.bin_count || out_formed !== exp_r.formed ||
            out_lost !== exp_r.lost || out_type_error !== exp_r.type_error) begin
          flag_error($sformatf({"mismatch: expected count=%0h formed=%0b lost=%0b err=%0b,",
                                " got count=%0h formed=%0b lost=%0b err=%0b"},
                               exp_r.bin_count, exp_r.formed, exp_r.lost, exp_r.type_error,
                               out_bin_count, out_formed, out_lost, out_type_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    in_valid               = 1'b0;
    in_req_type            = REQ_NOP;
    in_bound_before        = 1'b0;
    in_bound_after         = 1'b0;
    in_partner_before      = '0;
    in_partner_after       = '0;
    in_type_self           = '0;
    in_type_partner_before = '0;
    in_type_partner_after  = '0;
    in_read_row            = '0;
    in_read_col            = '0;
    model_num_types        = NUM_TYPES_RST;
    foreach (model_bins[i]) model_bins[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_types) begin
        drain_results();
        write_num_types(directed_rows[i].num_types);
      end
      send_transfer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end

    foreach (type_plan[p]) begin
      drain_results();
      write_num_types(type_plan[p]);
      idle_enabled = ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_PHASE) send_transfer(random_transition(), 1'b0, '0);
    end

    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
